@@ hw/rtl/pott_pkg.sv @@
// Package for the priority-ordered task table: sizes, codes and shared types.
`timescale 1ns / 1ps
package pott_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int MAX_RESULTS = 16;
    localparam int LINK_W = 5;
    localparam logic [LINK_W-1:0] LINK_NONE = 5'd31;
    localparam logic [7:0] DEFAULT_PRIORITY = 8'hff;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_WALK = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_FREE = 3'd4;

    // Result word handed from the sequencer to the output register.
    typedef struct packed {
        logic [3:0]  slot_out;
        logic [31:0] handle_out;
        logic [2:0]  status;
        logic        last;
    } t_result;
endpackage

@@ hw/rtl/pott_outreg.sv @@
// Output register holding one result word until it is taken.
`timescale 1ns / 1ps
module pott_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pott_pkg::t_result  i_res,
    input  logic [4:0]         i_count,
    output logic               o_full,
    input  logic               i_take,
    output pott_pkg::t_result  o_res,
    output logic [4:0]         o_count
);
    logic r_full;
    pott_pkg::t_result r_res;
    logic [4:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
            r_count <= i_count;
        end
    end

    assign o_full = r_full;
    assign o_res = r_res;
    assign o_count = r_count;
endmodule

@@ hw/rtl/priority_ordered_task_table_core.sv @@
// Top level of the priority-ordered task table: slot state and the list sequencer.
//   channel | direction | fields
//   in      | input     | operation, handle, priority_req, slot
//   out     | output    | slot_out, handle_out, occupied_count, status, last
// One item is taken at a time; ready is low while it is worked on.
// Add visits one list entry per cycle and find one slot per cycle.
// Walk emits one word each time the output register has drained.
// Reset is synchronous and frees all slots at once.
// A stalled output holds the sequencer in place.
`timescale 1ns / 1ps
module priority_ordered_task_table_core #(
    parameter int SLOTS = pott_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = pott_pkg::HANDLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_handle,
    input  logic [7:0]  i_priority_req,
    input  logic [3:0]  i_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_slot_out,
    output logic [31:0] o_handle_out,
    output logic [4:0]  o_occupied_count,
    output logic [2:0]  o_status,
    output logic        o_last
);
    localparam int SW = $clog2(SLOTS);
    localparam int LW = pott_pkg::LINK_W;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LINK = 6'b000100,
        S_WALK = 6'b001000,
        S_FIND = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [SLOTS-1:0] r_used;
    logic [HANDLE_BITS-1:0] r_hnd [SLOTS];
    logic [7:0] r_pri [SLOTS];
    logic [LW-1:0] r_prev [SLOTS];
    logic [LW-1:0] r_next [SLOTS];
    logic [CW-1:0] r_cnt;

    logic [HANDLE_BITS-1:0] r_h;
    logic [7:0] r_p;
    logic [SW-1:0] r_new;      // slot being added
    logic [LW-1:0] r_cur;      // list cursor
    logic [CW-1:0] r_steps;
    pott_pkg::t_result r_pend, n_pend;

    logic ob_full, load, take;
    pott_pkg::t_result ld_res;

    // Lowest free slot and list head, one priority encode each.
    logic [SW-1:0] free_idx, head_idx;
    logic free_any, head_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        head_idx = '0;
        head_any = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_idx = SW'(k);
                free_any = 1'b1;
            end
            if (r_used[k] && r_prev[k] == pott_pkg::LINK_NONE) begin
                head_idx = SW'(k);
                head_any = 1'b1;
            end
        end
    end

    logic [SW-1:0] cur;
    logic [LW-1:0] nx, cpv;
    logic nx_end;
    assign cur = r_cur[SW-1:0];
    assign nx = r_next[cur];
    assign cpv = r_prev[cur];
    assign nx_end = (nx >= LW'(SLOTS)) || !r_used[nx[SW-1:0]];

    logic [HW-1:0] cur_h;
    assign cur_h = r_hnd[cur][HW-1:0];

    logic [HANDLE_BITS-1:0] in_h;
    assign in_h = HANDLE_BITS'(i_handle);

    assign o_ready = (r_state == S_IDLE) && !ob_full;
    assign take = o_valid && i_ready;
    logic acc;
    assign acc = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        load = 1'b0;
        ld_res = r_pend;
        unique case (r_state)
            S_IDLE: if (acc) begin
                n_state = S_EMIT;
                if (i_operation == pott_pkg::OP_ADD && free_any && head_any) n_state = S_SCAN;
                if (i_operation == pott_pkg::OP_WALK && head_any) n_state = S_WALK;
                if (i_operation == pott_pkg::OP_FIND) n_state = S_FIND;
            end
            S_SCAN: if (r_p < r_pri[cur] || nx_end || r_steps == CW'(SLOTS - 1)) begin
                n_state = S_LINK;
            end
            S_LINK: n_state = S_EMIT;
            S_WALK: if (!ob_full) begin
                load = 1'b1;
                ld_res.slot_out = 4'(cur);
                ld_res.handle_out = 32'(cur_h);
                ld_res.status = pott_pkg::ST_OK;
                ld_res.last = nx_end || r_steps == CW'(SLOTS - 1)
                    || 32'(r_steps) + 1 >= pott_pkg::MAX_RESULTS;
                if (ld_res.last) n_state = S_IDLE;
            end
            S_FIND: begin
                if (r_used[cur] && r_hnd[cur] == r_h) begin
                    n_state = S_EMIT;
                end else if (r_steps == CW'(SLOTS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: if (!ob_full) begin
                load = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Link and flag state; handles carry no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cnt <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_pri[k] <= pott_pkg::DEFAULT_PRIORITY;
                r_prev[k] <= pott_pkg::LINK_NONE;
                r_next[k] <= pott_pkg::LINK_NONE;
            end
        end else begin
            if (r_state == S_IDLE && acc) begin
                if (i_operation == pott_pkg::OP_CLEAR) begin
                    r_used <= '0;
                    r_cnt <= '0;
                    for (int k = 0; k < SLOTS; k++) begin
                        r_pri[k] <= pott_pkg::DEFAULT_PRIORITY;
                        r_prev[k] <= pott_pkg::LINK_NONE;
                        r_next[k] <= pott_pkg::LINK_NONE;
                    end
                end else if (i_operation == pott_pkg::OP_ADD && free_any) begin
                    r_used[free_idx] <= 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    r_pri[free_idx] <= i_priority_req;
                    r_prev[free_idx] <= pott_pkg::LINK_NONE;
                    r_next[free_idx] <= pott_pkg::LINK_NONE;
                end else if (i_operation == pott_pkg::OP_DELETE
                             && 32'(i_slot) < SLOTS && r_used[i_slot[SW-1:0]]) begin
                    r_used[i_slot[SW-1:0]] <= 1'b0;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_prev[i_slot[SW-1:0]] < LW'(SLOTS))
                        r_next[r_prev[i_slot[SW-1:0]][SW-1:0]] <= r_next[i_slot[SW-1:0]];
                    if (r_next[i_slot[SW-1:0]] < LW'(SLOTS))
                        r_prev[r_next[i_slot[SW-1:0]][SW-1:0]] <= r_prev[i_slot[SW-1:0]];
                    r_prev[i_slot[SW-1:0]] <= pott_pkg::LINK_NONE;
                    r_next[i_slot[SW-1:0]] <= pott_pkg::LINK_NONE;
                    r_pri[i_slot[SW-1:0]] <= pott_pkg::DEFAULT_PRIORITY;
                end
            end
            if (r_state == S_LINK) begin
                // Insert before the cursor if it ranks lower, else after it when it is the last entry.
                if (r_p < r_pri[cur]) begin
                    r_prev[r_new] <= cpv;
                    r_next[r_new] <= r_cur;
                    if (cpv < LW'(SLOTS)) r_next[cpv[SW-1:0]] <= LW'(r_new);
                    r_prev[cur] <= LW'(r_new);
                end else if (nx_end) begin
                    r_prev[r_new] <= r_cur;
                    r_next[r_new] <= pott_pkg::LINK_NONE;
                    r_next[cur] <= LW'(r_new);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && acc && i_operation == pott_pkg::OP_ADD && free_any)
            r_hnd[free_idx] <= in_h;
    end

    // Pending result word for every operation; walk uses it only when the list is empty.
    always_comb begin
        n_pend = r_pend;
        if (r_state == S_IDLE && acc) begin
            n_pend = '0;
            n_pend.last = 1'b1;
            unique case (i_operation)
                pott_pkg::OP_ADD: begin
                    if (free_any) begin
                        n_pend.slot_out = 4'(free_idx);
                        n_pend.handle_out = 32'(in_h[HW-1:0]);
                    end else begin
                        n_pend.status = pott_pkg::ST_FULL;
                    end
                end
                pott_pkg::OP_DELETE: begin
                    n_pend.slot_out = i_slot;
                    if (32'(i_slot) < SLOTS && r_used[i_slot[SW-1:0]])
                        n_pend.handle_out = 32'(r_hnd[i_slot[SW-1:0]][HW-1:0]);
                    else
                        n_pend.status = pott_pkg::ST_FREE;
                end
                pott_pkg::OP_WALK: if (!head_any) n_pend.status = pott_pkg::ST_EMPTY;
                pott_pkg::OP_FIND: n_pend.status = pott_pkg::ST_NOT_FOUND;
                default: ;
            endcase
        end else if (r_state == S_FIND && r_used[cur] && r_hnd[cur] == r_h) begin
            n_pend.slot_out = 4'(cur);
            n_pend.handle_out = 32'(cur_h);
            n_pend.status = pott_pkg::ST_OK;
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (r_state == S_IDLE && acc) begin
            r_h <= in_h;
            r_p <= i_priority_req;
            r_new <= free_idx;
            r_steps <= '0;
            if (i_operation == pott_pkg::OP_FIND) begin
                r_cur <= '0;
            end else begin
                r_cur <= LW'(head_idx);
            end
        end else if (r_state == S_SCAN) begin
            if (!(r_p < r_pri[cur] || nx_end || r_steps == CW'(SLOTS - 1))) begin
                r_cur <= nx;
                r_steps <= r_steps + 1'b1;
            end
        end else if (r_state == S_WALK) begin
            if (!ob_full) begin
                r_cur <= nx;
                r_steps <= r_steps + 1'b1;
            end
        end else if (r_state == S_FIND) begin
            if (!(r_used[cur] && r_hnd[cur] == r_h)) begin
                r_cur <= r_cur + 1'b1;
                r_steps <= r_steps + 1'b1;
            end
        end
    end

    pott_pkg::t_result ob_res;
    logic [4:0] ob_cnt;
    pott_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (ld_res),
        .i_count (5'(r_cnt)),
        .o_full  (ob_full),
        .i_take  (take),
        .o_res   (ob_res),
        .o_count (ob_cnt)
    );

    assign o_valid = ob_full;
    assign o_slot_out = ob_res.slot_out;
    assign o_handle_out = ob_res.handle_out;
    assign o_status = ob_res.status;
    assign o_last = ob_res.last;
    assign o_occupied_count = ob_cnt;
endmodule
